// ----- hw/rtl/letterbox_bilinear_resize_assert.svh -----
// Assertion macros for the letterbox bilinear resize block.
`ifndef LETTERBOX_BILINEAR_RESIZE_ASSERT_SVH
`define LETTERBOX_BILINEAR_RESIZE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LBR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("letterbox resize check failed");

// Next-cycle implication, checked out of reset.
`define LBR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("letterbox resize check failed");

`endif

// ----- hw/rtl/lbr_pkg.sv -----
// Shared types and constants for the letterbox bilinear resize block.
package lbr_pkg;

   localparam int SRC_W_BITS = 10;
   localparam int SRC_H_BITS = 9;
   localparam int OUT_BITS   = 10;
   localparam int CSR_DATA_W = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int PAD_BITS   = 10;
   localparam int SCALE_BITS = 26;
   localparam int FRAC_BITS  = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_SIZE   = 2'd2;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EMIT = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE, ST_GEO_MINOR, ST_GEO_STEPX, ST_GEO_STEPY, ST_GEO_SCALE,
      ST_POS, ST_MUL, ST_ADDR, ST_BASE,
      ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_RD4,
      ST_INT1, ST_INT2, ST_OUT
   } lbr_state_type;

   typedef enum logic [1:0] {
      DIV_MINOR, DIV_STEPX, DIV_STEPY, DIV_SCALE
   } lbr_div_sel_type;

   typedef struct packed {
      logic            store_load;
      logic            div_start;
      lbr_div_sel_type div_sel;
      logic            pos_calc;
      logic            mul_calc;
      logic            addr_calc;
      logic            base_calc;
      logic            rd_en;
      logic [1:0]      rd_sel;
      logic            cap_en;
      logic [1:0]      cap_sel;
      logic            int1;
      logic            int2;
      logic            out_load;
   } lbr_cmd_type;

   typedef struct packed {
      logic frame_start;
      logic div_done;
      logic rsp_free;
   } lbr_status_type;

endpackage

// ----- hw/rtl/lbr_div.sv -----
// Restoring divider, one quotient bit per cycle.
module lbr_div #(
   parameter int NUM_W = 26,
   parameter int DEN_W = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W:0]   rem_ff, rem_in, shifted;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in, done_ff, done_in, ge;

   always_comb begin
      shifted = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
      ge      = shifted >= {1'b0, den};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = num;
         cnt_in = CNT_W'(NUM_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? shifted - {1'b0, den} : shifted;
         quo_in = {quo_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;
endmodule

// ----- hw/rtl/lbr_ctrl.sv -----
// Sequencer for loads, frame geometry and per-pixel interpolation.
module lbr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_operation,
   input  logic                    csr_wr_en,
   input  lbr_pkg::lbr_status_type status,
   output logic                    req_stall,
   output lbr_pkg::lbr_cmd_type    cmd
);
   lbr_pkg::lbr_state_type state_ff, state_in;
   logic hold_ff, run_ff, run_in, accept;

   assign req_stall = (state_ff != lbr_pkg::ST_IDLE) || hold_ff;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lbr_pkg::ST_IDLE:
            if (accept && req_operation == lbr_pkg::OP_EMIT) begin
               state_in = status.frame_start ? lbr_pkg::ST_GEO_MINOR : lbr_pkg::ST_POS;
            end
         lbr_pkg::ST_GEO_MINOR: if (status.div_done) state_in = lbr_pkg::ST_GEO_STEPX;
         lbr_pkg::ST_GEO_STEPX: if (status.div_done) state_in = lbr_pkg::ST_GEO_STEPY;
         lbr_pkg::ST_GEO_STEPY: if (status.div_done) state_in = lbr_pkg::ST_GEO_SCALE;
         lbr_pkg::ST_GEO_SCALE: if (status.div_done) state_in = lbr_pkg::ST_POS;
         lbr_pkg::ST_POS:  state_in = lbr_pkg::ST_MUL;
         lbr_pkg::ST_MUL:  state_in = lbr_pkg::ST_ADDR;
         lbr_pkg::ST_ADDR: state_in = lbr_pkg::ST_BASE;
         lbr_pkg::ST_BASE: state_in = lbr_pkg::ST_RD0;
         lbr_pkg::ST_RD0:  state_in = lbr_pkg::ST_RD1;
         lbr_pkg::ST_RD1:  state_in = lbr_pkg::ST_RD2;
         lbr_pkg::ST_RD2:  state_in = lbr_pkg::ST_RD3;
         lbr_pkg::ST_RD3:  state_in = lbr_pkg::ST_RD4;
         lbr_pkg::ST_RD4:  state_in = lbr_pkg::ST_INT1;
         lbr_pkg::ST_INT1: state_in = lbr_pkg::ST_INT2;
         lbr_pkg::ST_INT2: state_in = lbr_pkg::ST_OUT;
         lbr_pkg::ST_OUT:  if (status.rsp_free) state_in = lbr_pkg::ST_IDLE;
         default:          state_in = lbr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.div_sel = lbr_pkg::DIV_MINOR;
      unique case (state_ff)
         lbr_pkg::ST_IDLE:
            cmd.store_load = accept && (req_operation == lbr_pkg::OP_LOAD);
         lbr_pkg::ST_GEO_MINOR: begin
            cmd.div_sel   = lbr_pkg::DIV_MINOR;
            cmd.div_start = !run_ff;
         end
         lbr_pkg::ST_GEO_STEPX: begin
            cmd.div_sel   = lbr_pkg::DIV_STEPX;
            cmd.div_start = !run_ff;
         end
         lbr_pkg::ST_GEO_STEPY: begin
            cmd.div_sel   = lbr_pkg::DIV_STEPY;
            cmd.div_start = !run_ff;
         end
         lbr_pkg::ST_GEO_SCALE: begin
            cmd.div_sel   = lbr_pkg::DIV_SCALE;
            cmd.div_start = !run_ff;
         end
         lbr_pkg::ST_POS:  cmd.pos_calc  = 1'b1;
         lbr_pkg::ST_MUL:  cmd.mul_calc  = 1'b1;
         lbr_pkg::ST_ADDR: cmd.addr_calc = 1'b1;
         lbr_pkg::ST_BASE: cmd.base_calc = 1'b1;
         lbr_pkg::ST_RD0: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = 2'd0;
         end
         lbr_pkg::ST_RD1: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = 2'd1;
            cmd.cap_en  = 1'b1;
            cmd.cap_sel = 2'd0;
         end
         lbr_pkg::ST_RD2: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = 2'd2;
            cmd.cap_en  = 1'b1;
            cmd.cap_sel = 2'd1;
         end
         lbr_pkg::ST_RD3: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = 2'd3;
            cmd.cap_en  = 1'b1;
            cmd.cap_sel = 2'd2;
         end
         lbr_pkg::ST_RD4: begin
            cmd.cap_en  = 1'b1;
            cmd.cap_sel = 2'd3;
         end
         lbr_pkg::ST_INT1: cmd.int1 = 1'b1;
         lbr_pkg::ST_INT2: cmd.int2 = 1'b1;
         lbr_pkg::ST_OUT:  cmd.out_load = status.rsp_free;
         default: ;
      endcase
   end

   assign run_in = cmd.div_start || (run_ff && !status.div_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lbr_pkg::ST_IDLE;
         hold_ff  <= 1'b0;
         run_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         hold_ff  <= csr_wr_en;
         run_ff   <= run_in;
      end
   end
endmodule

// ----- hw/rtl/lbr_dp.sv -----
// Datapath: settings, frame store, geometry, addressing and interpolation.
module lbr_dp #(
   parameter int MAX_SRC_W = 640,
   parameter int MAX_SRC_H = 480,
   parameter int MAX_OUT   = 640,
   parameter int DIM_W     = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lbr_pkg::lbr_cmd_type                cmd,
   output lbr_pkg::lbr_status_type             status,
   input  logic                                csr_wr_en,
   input  logic [lbr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lbr_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [7:0]                          req_src_byte0,
   input  logic [7:0]                          req_src_byte1,
   input  logic [7:0]                          req_src_byte2,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [7:0]                          rsp_out_byte0,
   output logic [7:0]                          rsp_out_byte1,
   output logic [7:0]                          rsp_out_byte2,
   output logic                                rsp_last_pixel,
   output logic [lbr_pkg::PAD_BITS-1:0]        rsp_pad_left,
   output logic [lbr_pkg::PAD_BITS-1:0]        rsp_pad_top,
   output logic [lbr_pkg::SCALE_BITS-1:0]      rsp_scale_q16
);
   localparam int FB    = lbr_pkg::FRAC_BITS;
   localparam int DIV_W = DIM_W + FB;
   localparam int DEPTH = MAX_SRC_W * MAX_SRC_H;
   localparam int AW    = $clog2(DEPTH);
   localparam int LI_W  = $clog2(DEPTH + 1);
   localparam int SX_W  = DIM_W + DIV_W;

   // settings
   logic [lbr_pkg::SRC_W_BITS-1:0] cfg_w_ff;
   logic [lbr_pkg::SRC_H_BITS-1:0] cfg_h_ff;
   logic [lbr_pkg::OUT_BITS-1:0]   cfg_o_ff;
   logic [31:0] w32, h32, o32;
   logic [DIM_W-1:0] eff_w, eff_h, eff_o, eff_max;
   logic w_ge_h;

   always_comb begin
      w32 = (cfg_w_ff == '0) ? 32'd1 : ((32'(cfg_w_ff) > 32'(MAX_SRC_W)) ?
            32'(MAX_SRC_W) : 32'(cfg_w_ff));
      h32 = (cfg_h_ff == '0) ? 32'd1 : ((32'(cfg_h_ff) > 32'(MAX_SRC_H)) ?
            32'(MAX_SRC_H) : 32'(cfg_h_ff));
      o32 = (cfg_o_ff == '0) ? 32'd1 : ((32'(cfg_o_ff) > 32'(MAX_OUT)) ?
            32'(MAX_OUT) : 32'(cfg_o_ff));
      eff_w   = w32[DIM_W-1:0];
      eff_h   = h32[DIM_W-1:0];
      eff_o   = o32[DIM_W-1:0];
      w_ge_h  = eff_w >= eff_h;
      eff_max = w_ge_h ? eff_w : eff_h;
   end

   // counters
   logic [LI_W-1:0]    li_ff, li_in;
   logic [2*DIM_W-1:0] wh_ff;
   logic [DIM_W-1:0]   row_ff, row_in, col_ff, col_in;

   always_comb begin
      li_in  = li_ff;
      row_in = row_ff;
      col_in = col_ff;
      if (csr_wr_en) begin
         li_in  = '0;
         row_in = '0;
         col_in = '0;
      end else begin
         if (cmd.store_load) begin
            li_in = ((2*DIM_W)'(li_ff) + 1'b1 >= wh_ff) ? '0 : li_ff + 1'b1;
         end
         if (cmd.out_load) begin
            if (col_ff + 1'b1 >= eff_o) begin
               col_in = '0;
               row_in = (row_ff + 1'b1 >= eff_o) ? '0 : row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      wh_ff <= eff_w * eff_h;
      if (reset) begin
         cfg_w_ff <= lbr_pkg::SRC_W_BITS'(640);
         cfg_h_ff <= lbr_pkg::SRC_H_BITS'(480);
         cfg_o_ff <= lbr_pkg::OUT_BITS'(640);
         li_ff    <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         li_ff  <= li_in;
         row_ff <= row_in;
         col_ff <= col_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               lbr_pkg::CSR_SRC_WIDTH:  cfg_w_ff <= csr_wdata[lbr_pkg::SRC_W_BITS-1:0];
               lbr_pkg::CSR_SRC_HEIGHT: cfg_h_ff <= csr_wdata[lbr_pkg::SRC_H_BITS-1:0];
               lbr_pkg::CSR_OUT_SIZE:   cfg_o_ff <= csr_wdata[lbr_pkg::OUT_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   // geometry divider
   logic [DIV_W-1:0] div_num, div_q;
   logic [DIM_W-1:0] div_den;
   logic             div_done;
   logic [DIM_W-1:0] rw_ff, rh_ff;
   logic [DIV_W-1:0] stepx_ff, stepy_ff, scale_ff;

   always_comb begin
      div_num = '0;
      div_den = eff_max;
      case (cmd.div_sel)
         lbr_pkg::DIV_MINOR: begin
            div_num = w_ge_h ? DIV_W'(eff_h * eff_o) : DIV_W'(eff_w * eff_o);
            div_den = w_ge_h ? eff_w : eff_h;
         end
         lbr_pkg::DIV_STEPX: begin
            div_num = {eff_w, {FB{1'b0}}};
            div_den = rw_ff;
         end
         lbr_pkg::DIV_STEPY: begin
            div_num = {eff_h, {FB{1'b0}}};
            div_den = rh_ff;
         end
         default: begin
            div_num = {eff_o, {FB{1'b0}}};
            div_den = eff_max;
         end
      endcase
   end

   lbr_div #(.NUM_W(DIV_W), .DEN_W(DIM_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_q)
   );

   always_ff @(posedge clock) begin
      if (div_done) begin
         case (cmd.div_sel)
            lbr_pkg::DIV_MINOR: begin
               rw_ff <= w_ge_h ? eff_o : div_q[DIM_W-1:0];
               rh_ff <= w_ge_h ? div_q[DIM_W-1:0] : eff_o;
            end
            lbr_pkg::DIV_STEPX: stepx_ff <= (rw_ff == '0) ? '0 : div_q;
            lbr_pkg::DIV_STEPY: stepy_ff <= (rh_ff == '0) ? '0 : div_q;
            default:            scale_ff <= div_q;
         endcase
      end
   end

   // pixel position and source coordinates
   logic [DIM_W-1:0]   padl_ff, padt_ff, dx_ff, dy_ff, padl, padt;
   logic               in_box_ff, last_ff, in_box;
   logic [SX_W-1:0]    sx_ff, sy_ff;
   logic [2*DIM_W-1:0] xi, yi;
   logic [DIM_W-1:0]   x0, y0, x0_ff, x1_ff, y0_ff, y1_ff;
   logic [DIM_W:0]     x0p, y0p;
   logic [FB-1:0]      fx_ff, fy_ff;
   logic [2*DIM_W-1:0] rb0_ff, rb1_ff;

   always_comb begin
      padl   = (eff_o - rw_ff) >> 1;
      padt   = (eff_o - rh_ff) >> 1;
      in_box = (col_ff >= padl) && ({1'b0, col_ff} < {1'b0, padl} + {1'b0, rw_ff}) &&
               (row_ff >= padt) && ({1'b0, row_ff} < {1'b0, padt} + {1'b0, rh_ff});
      xi  = sx_ff[SX_W-1:FB];
      yi  = sy_ff[SX_W-1:FB];
      x0  = (xi > (2*DIM_W)'(eff_w - 1'b1)) ? eff_w - 1'b1 : xi[DIM_W-1:0];
      y0  = (yi > (2*DIM_W)'(eff_h - 1'b1)) ? eff_h - 1'b1 : yi[DIM_W-1:0];
      x0p = {1'b0, x0} + 1'b1;
      y0p = {1'b0, y0} + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.pos_calc) begin
         padl_ff   <= padl;
         padt_ff   <= padt;
         in_box_ff <= in_box;
         dx_ff     <= col_ff - padl;
         dy_ff     <= row_ff - padt;
         last_ff   <= (row_ff == eff_o - 1'b1) && (col_ff == eff_o - 1'b1);
      end
      if (cmd.mul_calc) begin
         sx_ff <= dx_ff * stepx_ff;
         sy_ff <= dy_ff * stepy_ff;
      end
      if (cmd.addr_calc) begin
         x0_ff <= x0;
         y0_ff <= y0;
         x1_ff <= (x0p < {1'b0, eff_w}) ? x0p[DIM_W-1:0] : eff_w - 1'b1;
         y1_ff <= (y0p < {1'b0, eff_h}) ? y0p[DIM_W-1:0] : eff_h - 1'b1;
         fx_ff <= sx_ff[FB-1:0];
         fy_ff <= sy_ff[FB-1:0];
      end
      if (cmd.base_calc) begin
         rb0_ff <= y0_ff * eff_w;
         rb1_ff <= y1_ff * eff_w;
      end
   end

   // frame store, single port
   logic [23:0]        mem [DEPTH];
   logic [23:0]        rd_data_ff;
   logic [2*DIM_W-1:0] rd_full;
   logic [23:0]        pix_ff [4];

   always_comb begin
      case (cmd.rd_sel)
         2'd0:    rd_full = rb0_ff + {{DIM_W{1'b0}}, x0_ff};
         2'd1:    rd_full = rb0_ff + {{DIM_W{1'b0}}, x1_ff};
         2'd2:    rd_full = rb1_ff + {{DIM_W{1'b0}}, x0_ff};
         default: rd_full = rb1_ff + {{DIM_W{1'b0}}, x1_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.store_load) begin
         mem[li_ff[AW-1:0]] <= {req_src_byte2, req_src_byte1, req_src_byte0};
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_full[AW-1:0]];
      end
      if (cmd.cap_en) begin
         pix_ff[cmd.cap_sel] <= rd_data_ff;
      end
   end

   // interpolation, two multiply stages per channel
   logic [23:0] top_ff [3];
   logic [23:0] bot_ff [3];
   logic [7:0]  val_ff [3];
   logic [16:0] ax, ay;
   logic [24:0] top_sum [3];
   logic [24:0] bot_sum [3];
   logic [40:0] fin_sum [3];

   always_comb begin
      ax = 17'h10000 - {1'b0, fx_ff};
      ay = 17'h10000 - {1'b0, fy_ff};
      for (int c = 0; c < 3; c++) begin
         top_sum[c] = pix_ff[0][8*c +: 8] * ax + pix_ff[1][8*c +: 8] * fx_ff;
         bot_sum[c] = pix_ff[2][8*c +: 8] * ax + pix_ff[3][8*c +: 8] * fx_ff;
         fin_sum[c] = top_ff[c] * ay + bot_ff[c] * fy_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         if (cmd.int1) begin
            top_ff[c] <= top_sum[c][23:0];
            bot_ff[c] <= bot_sum[c][23:0];
         end
         if (cmd.int2) begin
            val_ff[c] <= fin_sum[c][39:32];
         end
      end
   end

   // output word register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.out_load || (rsp_valid_ff && rsp_stall);
      end
      if (cmd.out_load) begin
         rsp_out_byte0  <= in_box_ff ? val_ff[2] : 8'd0;
         rsp_out_byte1  <= in_box_ff ? val_ff[1] : 8'd0;
         rsp_out_byte2  <= in_box_ff ? val_ff[0] : 8'd0;
         rsp_last_pixel <= last_ff;
         rsp_pad_left   <= lbr_pkg::PAD_BITS'(padl_ff);
         rsp_pad_top    <= lbr_pkg::PAD_BITS'(padt_ff);
         rsp_scale_q16  <= lbr_pkg::SCALE_BITS'(scale_ff);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign status.rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign status.div_done    = div_done;
   assign status.frame_start = (row_ff == '0) && (col_ff == '0);
endmodule

// ----- hw/rtl/letterbox_bilinear_resize.sv -----
// Top level of the letterbox bilinear resize block.
//
// Usage: the request channel (req_valid / req_stall) carries one word per
// operation. A load word (req_operation = 0) writes req_src_byte0..2 into the
// frame store at the next raster position and gives no response; loads are
// taken one per cycle while the sequencer is idle and no csr write holds the
// channel. An emit word (req_operation = 1) produces one output pixel on the
// response channel (rsp_valid / rsp_stall) in raster order of the out_size x
// out_size image, zero outside the centered letterbox, with the channel order
// reversed inside it. An accepted emit steps through position, multiply,
// address and base, four neighbor reads of the single-port frame store and
// the two multiply stages before rsp_valid. The first pixel of each frame
// adds four serial divisions (one quotient bit per cycle) for resized size,
// x/y steps and scale. A new word is taken once the previous emit has left
// the sequencer, while its response may still wait. A csr write restarts
// both raster sequences and holds the request channel in the cycle after it.
// Reset: synchronous; settings return to 640 x 480 source and 640 output,
// counters clear; the frame store holds garbage until loaded.
// Receiver stall: the response word holds and the sequencer waits with the
// next finished pixel until the response register drains.
module letterbox_bilinear_resize #(
   parameter int MAX_SRC_W = 640,
   parameter int MAX_SRC_H = 480,
   parameter int MAX_OUT   = 640
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_operation,
   input  logic [7:0]                        req_src_byte0,
   input  logic [7:0]                        req_src_byte1,
   input  logic [7:0]                        req_src_byte2,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_out_byte0,
   output logic [7:0]                        rsp_out_byte1,
   output logic [7:0]                        rsp_out_byte2,
   output logic                              rsp_last_pixel,
   output logic [lbr_pkg::PAD_BITS-1:0]      rsp_pad_left,
   output logic [lbr_pkg::PAD_BITS-1:0]      rsp_pad_top,
   output logic [lbr_pkg::SCALE_BITS-1:0]    rsp_scale_q16,
   input  logic                              csr_wr_en,
   input  logic [lbr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lbr_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   // widest dimension decides every coordinate width
   localparam int BW_W  = $clog2(MAX_SRC_W + 1);
   localparam int BW_H  = $clog2(MAX_SRC_H + 1);
   localparam int BW_O  = $clog2(MAX_OUT + 1);
   localparam int BW_WH = (BW_W > BW_H) ? BW_W : BW_H;
   localparam int DIM_W = (BW_WH > BW_O) ? BW_WH : BW_O;

   lbr_pkg::lbr_cmd_type    cmd;
   lbr_pkg::lbr_status_type status;

   lbr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .csr_wr_en     (csr_wr_en),
      .status        (status),
      .req_stall     (req_stall),
      .cmd           (cmd)
   );

   lbr_dp #(
      .MAX_SRC_W (MAX_SRC_W),
      .MAX_SRC_H (MAX_SRC_H),
      .MAX_OUT   (MAX_OUT),
      .DIM_W     (DIM_W)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_src_byte0  (req_src_byte0),
      .req_src_byte1  (req_src_byte1),
      .req_src_byte2  (req_src_byte2),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_out_byte0  (rsp_out_byte0),
      .rsp_out_byte1  (rsp_out_byte1),
      .rsp_out_byte2  (rsp_out_byte2),
      .rsp_last_pixel (rsp_last_pixel),
      .rsp_pad_left   (rsp_pad_left),
      .rsp_pad_top    (rsp_pad_top),
      .rsp_scale_q16  (rsp_scale_q16)
   );

`include "letterbox_bilinear_resize_assert.svh"

   // an accepted emit occupies the sequencer
   `LBR_ASSERT_NEXT(a_emit_busy, clock, reset, req_valid && !req_stall && req_operation, req_stall)
   // a settings write blocks the next request
   `LBR_ASSERT_NEXT(a_csr_hold, clock, reset, csr_wr_en, req_stall)
   // no load is written while a pixel is being fetched
   `LBR_ASSERT_NOW(a_port_excl, clock, reset, cmd.rd_en, !cmd.store_load)
endmodule
